// ===== hdl/crp_pkg.sv =====
// Shared widths, types and register codes of the chassis velocity ramp planner.
package crp_pkg;

    localparam int RPM_W  = 16;
    localparam int VEL_W  = 24;
    localparam int GAIN_W = 24;
    localparam int STEP_W = 23;
    localparam int CFG_W  = 24;

    // The wheel difference needs two guard bits; its magnitude stays below 2^17.
    localparam int DIFF_W = RPM_W + 2;
    localparam int MAG_W  = RPM_W + 1;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);

    typedef logic signed [VEL_W-1:0] vel_t;

    typedef enum logic {
        CFG_SPEED_GAIN = 1'b0,
        CFG_RAMP_STEP  = 1'b1
    } cfg_index_t;

    // One measured item as it leaves the measurement pipeline.
    typedef struct packed {
        vel_t meas_vx;
        vel_t target_vx;
        vel_t target_vy;
    } meas_item_t;

endpackage

// ===== hdl/crp_measure.sv =====
// Two-stage measurement pipeline: wheel difference magnitude, then gain product.
module crp_measure import crp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [GAIN_W-1:0]        speed_gain,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [RPM_W-1:0]  wheel_a_rpm,
    input  logic signed [RPM_W-1:0]  wheel_b_rpm,
    input  logic signed [RPM_W-1:0]  wheel_c_rpm,
    input  logic signed [RPM_W-1:0]  wheel_d_rpm,
    input  vel_t                     target_vx,
    input  vel_t                     target_vy,
    output logic                     out_valid,
    input  logic                     out_ready,
    output meas_item_t               out_item
);

    localparam int PROD_W = GAIN_W + MAG_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int SHR_W  = RND_W - 8;

    logic                     a_valid_reg, a_valid_next;
    logic [MAG_W-1:0]         a_mag_reg;
    vel_t                     a_tx_reg;
    vel_t                     a_ty_reg;
    logic                     b_valid_reg, b_valid_next;
    meas_item_t               b_item_reg;

    logic signed [DIFF_W-1:0] diff13;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [RND_W-1:0]         rnd;
    logic [SHR_W-1:0]         shr;
    vel_t                     meas_sat;
    logic                     in_xfer;
    logic                     b_load;

    // The second differential term is the negation of the first, so the X speed
    // is gain times twice |d13|: (2*g*mag + 256) >> 9 equals (g*mag + 128) >> 8.
    assign diff13 = DIFF_W'(wheel_a_rpm) + DIFF_W'(wheel_c_rpm)
                  - DIFF_W'(wheel_b_rpm) - DIFF_W'(wheel_d_rpm);
    assign mag    = diff13[DIFF_W-1] ? MAG_W'(-diff13) : MAG_W'(diff13);

    assign prod = PROD_W'(speed_gain) * PROD_W'(a_mag_reg);
    assign rnd  = RND_W'(prod) + RND_W'(128);
    assign shr  = rnd[RND_W-1:8];

    always_comb begin
        if (|shr[SHR_W-1:VEL_W-1]) begin
            meas_sat = {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            meas_sat = {1'b0, shr[VEL_W-2:0]};
        end
    end

    assign b_load   = a_valid_reg && (!b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || b_load;
    assign in_xfer  = in_valid && in_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (in_xfer) begin
            a_valid_next = 1'b1;
        end else if (b_load) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (b_load) begin
            b_valid_next = 1'b1;
        end else if (out_ready) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            a_mag_reg <= mag;
            a_tx_reg  <= target_vx;
            a_ty_reg  <= target_vy;
        end
        if (b_load) begin
            b_item_reg.meas_vx   <= meas_sat;
            b_item_reg.target_vx <= a_tx_reg;
            b_item_reg.target_vy <= a_ty_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !out_ready |=> b_valid_reg)
        else $error("measured item dropped while stalled");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> a_mag_reg <= MAG_W'(131070))
        else $error("wheel difference magnitude out of range");

    a_meas_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> !b_item_reg.meas_vx[VEL_W-1])
        else $error("measured X speed negative");

endmodule

// ===== hdl/crp_ramp_axis.sv =====
// Planned velocity of one axis, stepped on each load and never past its target.
module crp_ramp_axis import crp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [STEP_W-1:0] ramp_step,
    input  vel_t              target,
    input  vel_t              meas,
    output vel_t              plan
);

    localparam int SUM_W = VEL_W + 1;

    vel_t                    plan_reg, plan_next;
    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] up_sum;
    logic signed [SUM_W-1:0] dn_sum;
    vel_t                    up_sat;
    vel_t                    dn_sat;
    vel_t                    moved;

    assign step_ext = $signed({2'b00, ramp_step});
    assign up_sum   = SUM_W'(plan_reg) + step_ext;
    assign dn_sum   = SUM_W'(plan_reg) - step_ext;

    // Overflow shows as a disagreement between the two top bits of the sum.
    always_comb begin
        if (up_sum[SUM_W-1] != up_sum[SUM_W-2]) begin
            up_sat = up_sum[SUM_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            up_sat = up_sum[VEL_W-1:0];
        end
        if (dn_sum[SUM_W-1] != dn_sum[SUM_W-2]) begin
            dn_sat = dn_sum[SUM_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            dn_sat = dn_sum[VEL_W-1:0];
        end
    end

    always_comb begin
        moved     = up_sat;
        plan_next = '0;
        if (target > 0) begin
            moved     = (meas < target) ? up_sat : dn_sat;
            plan_next = (moved > target) ? target : moved;
        end else if (target < 0) begin
            moved     = (target < meas) ? dn_sat : up_sat;
            plan_next = (moved < target) ? target : moved;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_reg <= '0;
        end else if (load) begin
            plan_reg <= plan_next;
        end
    end

    assign plan = plan_reg;

    a_clamp_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        load && target > 0 |=> plan_reg <= $past(target))
        else $error("plan passed a positive target");

    a_clamp_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        load && target < 0 |=> plan_reg >= $past(target))
        else $error("plan passed a negative target");

    a_zero_target: assert property (@(posedge aclk) disable iff (!aresetn)
        load && target == 0 |=> plan_reg == 0)
        else $error("plan not zero for a zero target");

endmodule

// ===== hdl/chassis_velocity_ramp_planner.sv =====
// Top level of the chassis velocity ramp planner: configuration, result stage and ports.
//
// Each input transfer yields exactly one result transfer, in order. The block takes a new
// item every cycle when the result side keeps up; an accepted item passes through the
// first stage, which stores the wheel difference magnitude, then the second stage, which
// stores the rounded gain product, and then the ramp step, which updates the planned
// velocities and loads the result register. The ramp step reads the planned velocity left
// by the previous item, and that feedback still allows one item per cycle when the result
// side keeps up. Measured X speed is never negative, and measured Y speed is always zero
// because the two differential wheel terms cancel. Write speed_gain and ramp_step only while no
// item is in flight; after reset the gain is 0 and the step is 655 (about 0.01 in Q8.16).
module chassis_velocity_ramp_planner import crp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  cfg_index_t               cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [RPM_W-1:0]  s_wheel_a_rpm,
    input  logic signed [RPM_W-1:0]  s_wheel_b_rpm,
    input  logic signed [RPM_W-1:0]  s_wheel_c_rpm,
    input  logic signed [RPM_W-1:0]  s_wheel_d_rpm,
    input  vel_t                     s_target_vx,
    input  vel_t                     s_target_vy,
    output logic                     m_valid,
    input  logic                     m_ready,
    output vel_t                     m_planned_vx,
    output vel_t                     m_planned_vy,
    output vel_t                     m_measured_vx,
    output vel_t                     m_measured_vy
);

    logic [GAIN_W-1:0] gain_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg, m_valid_next;
    vel_t              meas_vx_reg;

    logic              meas_valid;
    logic              meas_ready;
    meas_item_t        meas_item;
    logic              out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
            step_reg <= STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SPEED_GAIN: gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_RAMP_STEP:  step_reg <= cfg_wdata[STEP_W-1:0];
            endcase
        end
    end

    crp_measure u_measure (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .speed_gain  (gain_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .wheel_a_rpm (s_wheel_a_rpm),
        .wheel_b_rpm (s_wheel_b_rpm),
        .wheel_c_rpm (s_wheel_c_rpm),
        .wheel_d_rpm (s_wheel_d_rpm),
        .target_vx   (s_target_vx),
        .target_vy   (s_target_vy),
        .out_valid   (meas_valid),
        .out_ready   (meas_ready),
        .out_item    (meas_item)
    );

    // The result register takes a new item when it is empty or its transfer completes.
    assign meas_ready = !m_valid_reg || m_ready;
    assign out_load   = meas_valid && meas_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            meas_vx_reg <= meas_item.meas_vx;
        end
    end

    crp_ramp_axis u_ramp_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .ramp_step (step_reg),
        .target    (meas_item.target_vx),
        .meas      (meas_item.meas_vx),
        .plan      (m_planned_vx)
    );

    crp_ramp_axis u_ramp_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .ramp_step (step_reg),
        .target    (meas_item.target_vy),
        .meas      ('0),
        .plan      (m_planned_vy)
    );

    assign m_valid       = m_valid_reg;
    assign m_measured_vx = meas_vx_reg;
    assign m_measured_vy = '0;

endmodule

// ===== verif/chassis_velocity_ramp_planner_tb.sv =====
// Self-checking testbench for the chassis velocity ramp planner: directed rows, then random runs.
module chassis_velocity_ramp_planner_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import crp_pkg::*;

    typedef logic signed [RPM_W-1:0] rpm_t;

    typedef struct packed {
        rpm_t wheel_a;
        rpm_t wheel_b;
        rpm_t wheel_c;
        rpm_t wheel_d;
        vel_t target_vx;
        vel_t target_vy;
    } chassis_sample_t;

    typedef struct packed {
        vel_t planned_vx;
        vel_t planned_vy;
        vel_t measured_vx;
        vel_t measured_vy;
    } ramp_result_t;

    typedef struct packed {
        logic                set_regs;
        logic [GAIN_W-1:0]   gain;
        logic [STEP_W-1:0]   step;
        chassis_sample_t     sample;
        logic                typed;
        ramp_result_t        want;
    } stim_row_t;

    localparam rpm_t RPM_HI = 16'sh7FFF;
    localparam rpm_t RPM_LO = 16'sh8000;
    localparam vel_t VEL_HI = 24'sh7FFFFF;
    localparam vel_t VEL_LO = 24'sh800000;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;
    localparam ramp_result_t NO_RESULT = '0;
    localparam int DIR_ROWS = 16;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 135;

    // Rows marked typed carry a hand-written result; the others rely on the predictor.
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{1'b0, 24'd0, 23'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd0},
          1'b1, '{24'sd0, 24'sd0, 24'sd0, 24'sd0}},
        '{1'b0, 24'd0, 23'd0, '{RPM_HI, RPM_LO, RPM_HI, RPM_LO, 24'sd1000, -24'sd1000},
          1'b1, '{24'sd655, -24'sd655, 24'sd0, 24'sd0}},
        '{1'b0, 24'd0, 23'd0, '{RPM_HI, RPM_LO, RPM_HI, RPM_LO, 24'sd1000, -24'sd1000},
          1'b1, '{24'sd1000, -24'sd1000, 24'sd0, 24'sd0}},
        '{1'b0, 24'd0, 23'd0, '{RPM_LO, RPM_HI, RPM_LO, RPM_HI, VEL_HI, VEL_LO},
          1'b1, '{24'sd1655, -24'sd1655, 24'sd0, 24'sd0}},
        '{1'b0, 24'd0, 23'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd0},
          1'b1, '{24'sd0, 24'sd0, 24'sd0, 24'sd0}},
        '{1'b1, 24'd256, 23'd100, '{16'sd100, 16'sd0, 16'sd0, 16'sd0, 24'sd1000, -24'sd1000},
          1'b0, NO_RESULT},
        '{1'b0, 24'd0, 23'd0, '{16'sd100, 16'sd0, 16'sd0, 16'sd0, 24'sd50, 24'sd50},
          1'b0, NO_RESULT},
        '{1'b0, 24'd0, 23'd0, '{16'sd0, 16'sd1, 16'sd0, 16'sd0, 24'sd1, -24'sd1},
          1'b0, NO_RESULT},
        '{1'b0, 24'd0, 23'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, -24'sd50, 24'sd0},
          1'b0, NO_RESULT},
        '{1'b1, GAIN_MAX, STEP_MAX, '{RPM_HI, RPM_LO, RPM_HI, RPM_LO, VEL_HI, VEL_LO},
          1'b0, NO_RESULT},
        '{1'b0, 24'd0, 23'd0, '{RPM_HI, RPM_LO, RPM_HI, RPM_LO, VEL_HI, VEL_HI},
          1'b0, NO_RESULT},
        '{1'b0, 24'd0, 23'd0, '{RPM_LO, RPM_HI, RPM_LO, RPM_HI, VEL_LO, VEL_LO},
          1'b0, NO_RESULT},
        '{1'b0, 24'd0, 23'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd1, -24'sd1},
          1'b0, NO_RESULT},
        '{1'b1, 24'd0, 23'd0, '{16'sd1234, -16'sd5678, 16'sd91, -16'sd4321, 24'sd5000,
          -24'sd5000}, 1'b0, NO_RESULT},
        '{1'b0, 24'd0, 23'd0, '{16'sd1234, -16'sd5678, 16'sd91, -16'sd4321, 24'sd0, 24'sd0},
          1'b1, '{24'sd0, 24'sd0, 24'sd0, 24'sd0}},
        '{1'b1, 24'd4096, 23'd655, '{RPM_HI, RPM_HI, RPM_LO, RPM_LO, VEL_LO, VEL_HI},
          1'b0, NO_RESULT}
    };

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    cfg_index_t        cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    rpm_t              s_wheel_a_rpm;
    rpm_t              s_wheel_b_rpm;
    rpm_t              s_wheel_c_rpm;
    rpm_t              s_wheel_d_rpm;
    vel_t              s_target_vx;
    vel_t              s_target_vy;
    logic              m_valid;
    logic              m_ready;
    vel_t              m_planned_vx;
    vel_t              m_planned_vy;
    vel_t              m_measured_vx;
    vel_t              m_measured_vy;

    logic [GAIN_W-1:0] gain_q;
    logic [STEP_W-1:0] step_q;
    vel_t              plan_x;
    vel_t              plan_y;
    ramp_result_t      pending_results[$];
    int                fail_count = 0;
    bit                idle_on = 1'b1;

    chassis_velocity_ramp_planner dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_wheel_a_rpm (s_wheel_a_rpm),
        .s_wheel_b_rpm (s_wheel_b_rpm),
        .s_wheel_c_rpm (s_wheel_c_rpm),
        .s_wheel_d_rpm (s_wheel_d_rpm),
        .s_target_vx   (s_target_vx),
        .s_target_vy   (s_target_vy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_planned_vx  (m_planned_vx),
        .m_planned_vy  (m_planned_vy),
        .m_measured_vx (m_measured_vx),
        .m_measured_vy (m_measured_vy)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint clamp_vel(longint v);
        if (v > longint'(VEL_HI)) return longint'(VEL_HI);
        if (v < longint'(VEL_LO)) return longint'(VEL_LO);
        return v;
    endfunction

    // The gain products carry 25 fraction bits; adding half an LSB and an arithmetic shift
    // rounds half toward plus infinity.
    function automatic void measure_speed(input chassis_sample_t smp, output vel_t mx,
                                          output vel_t my);
        longint diff_ac;
        longint diff_bd;
        longint mag_ac;
        longint mag_bd;
        diff_ac = longint'(smp.wheel_a) + longint'(smp.wheel_c)
                - longint'(smp.wheel_b) - longint'(smp.wheel_d);
        diff_bd = longint'(smp.wheel_b) + longint'(smp.wheel_d)
                - longint'(smp.wheel_a) - longint'(smp.wheel_c);
        mag_ac = (diff_ac < 0) ? -diff_ac : diff_ac;
        mag_bd = (diff_bd < 0) ? -diff_bd : diff_bd;
        mx = vel_t'(clamp_vel((longint'(gain_q) * (mag_ac + mag_bd) + 256) >>> 9));
        my = vel_t'(clamp_vel((longint'(gain_q) * (mag_bd - mag_ac) + 256) >>> 9));
    endfunction

    function automatic vel_t ramp_toward(vel_t plan, vel_t target, vel_t meas);
        longint p;
        longint t;
        longint m;
        longint step;
        p = plan;
        t = target;
        m = meas;
        step = longint'(step_q);
        if (t > 0) begin
            p = (m < t) ? clamp_vel(p + step) : clamp_vel(p - step);
            if (p > t) p = t;
        end else if (t < 0) begin
            p = (t < m) ? clamp_vel(p - step) : clamp_vel(p + step);
            if (p < t) p = t;
        end else begin
            p = 0;
        end
        return vel_t'(p);
    endfunction

    function automatic vel_t pick_target();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return VEL_HI;
            2: return VEL_LO;
            3, 4: return vel_t'($urandom);
            default: return vel_t'(int'($urandom_range(0, 524288)) - 262144);
        endcase
    endfunction

    function automatic rpm_t pick_rpm();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? RPM_HI : RPM_LO;
            1, 2, 3: return rpm_t'($urandom);
            default: return rpm_t'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic advance_plan(chassis_sample_t smp, logic typed, ramp_result_t want);
        vel_t mx;
        vel_t my;
        measure_speed(smp, mx, my);
        plan_x = ramp_toward(plan_x, smp.target_vx, mx);
        plan_y = ramp_toward(plan_y, smp.target_vy, my);
        pending_results.push_back(typed ? want : ramp_result_t'({plan_x, plan_y, mx, my}));
    endtask

    task automatic drive_sample(chassis_sample_t smp, logic typed, ramp_result_t want);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_wheel_a_rpm = smp.wheel_a;
        s_wheel_b_rpm = smp.wheel_b;
        s_wheel_c_rpm = smp.wheel_c;
        s_wheel_d_rpm = smp.wheel_d;
        s_target_vx = smp.target_vx;
        s_target_vy = smp.target_vy;
        do @(posedge aclk); while (!s_ready);
        advance_plan(smp, typed, want);
    endtask

    // Holds the input side off until every expected result has been taken.
    task automatic settle_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        if (idx == CFG_SPEED_GAIN) gain_q = data[GAIN_W-1:0];
        else step_q = data[STEP_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        ramp_result_t got;
        ramp_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_planned_vx, m_planned_vy, m_measured_vx, m_measured_vy};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transfer: planned %0d/%0d measured %0d/%0d",
                             got.planned_vx, got.planned_vy, got.measured_vx, got.measured_vy);
            end else begin
                want = pending_results.pop_front();
                if (got.planned_vx !== want.planned_vx || got.planned_vy !== want.planned_vy ||
                    got.measured_vx !== want.measured_vx ||
                    got.measured_vy !== want.measured_vy) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected planned %0d/%0d measured %0d/%0d, got %0d/%0d %0d/%0d",
                                 want.planned_vx, want.planned_vy, want.measured_vx,
                                 want.measured_vy, got.planned_vx, got.planned_vy,
                                 got.measured_vx, got.measured_vy);
                end
            end
        end
    end

    initial begin
        #(4_000_000);
        $display("simulation failed");
        $finish;
    end

    initial begin
        chassis_sample_t   smp;
        vel_t              hold_vx;
        vel_t              hold_vy;
        vel_t              mx;
        vel_t              my;
        int                run_left;
        bit                track_meas;
        logic [GAIN_W-1:0] g;
        logic [CFG_W-1:0]  sw;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SPEED_GAIN;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_wheel_a_rpm = '0;
        s_wheel_b_rpm = '0;
        s_wheel_c_rpm = '0;
        s_wheel_d_rpm = '0;
        s_target_vx = '0;
        s_target_vy = '0;
        gain_q = '0;
        step_q = STEP_RESET;
        plan_x = '0;
        plan_y = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].set_regs) begin
                settle_idle();
                write_reg(CFG_SPEED_GAIN, DIRECTED[r].gain);
                write_reg(CFG_RAMP_STEP, CFG_W'(DIRECTED[r].step));
            end
            drive_sample(DIRECTED[r].sample, DIRECTED[r].typed, DIRECTED[r].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle_idle();
            case (phase)
                0: begin g = GAIN_W'($urandom_range(0, 4096)); sw = CFG_W'(655); end
                1: begin g = GAIN_MAX; sw = '1; end
                2: begin g = '0; sw = '0; end
                3: begin g = GAIN_W'($urandom); sw = CFG_W'($urandom); end
                4: begin g = GAIN_W'($urandom_range(0, 4095)); sw = CFG_W'($urandom_range(0, 4095)); end
                5: begin g = GAIN_W'(1); sw = CFG_W'(1); end
                6: begin g = GAIN_W'($urandom_range(0, 1 << 20)); sw = CFG_W'($urandom_range(0, 1 << 16)); end
                default: begin
                    g = GAIN_W'($urandom_range(0, 1 << 14));
                    sw = CFG_W'($urandom_range(1, 1 << 14));
                end
            endcase
            write_reg(CFG_SPEED_GAIN, g);
            write_reg(CFG_RAMP_STEP, sw);
            idle_on = (phase != PHASES - 1);
            run_left = 0;
            track_meas = 1'b0;
            hold_vx = '0;
            hold_vy = '0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == 60) settle_idle();
                smp.wheel_a = pick_rpm();
                smp.wheel_b = pick_rpm();
                smp.wheel_c = pick_rpm();
                smp.wheel_d = pick_rpm();
                // Targets are held for a run of samples so the plan can ramp into its clamp.
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 30);
                    track_meas = ($urandom_range(0, 4) == 0);
                    hold_vx = pick_target();
                    hold_vy = pick_target();
                end
                run_left--;
                if (track_meas) begin
                    // Targets sit right next to the measured speed to hit the compare edges.
                    measure_speed(smp, mx, my);
                    smp.target_vx = vel_t'(longint'(mx) + longint'($urandom_range(0, 6)) - 3);
                    smp.target_vy = vel_t'(longint'(my) + longint'($urandom_range(0, 6)) - 3);
                end else if ($urandom_range(0, 19) == 0) begin
                    smp.target_vx = vel_t'($urandom);
                    smp.target_vy = vel_t'($urandom);
                end else begin
                    smp.target_vx = hold_vx;
                    smp.target_vy = hold_vy;
                end
                drive_sample(smp, 1'b0, NO_RESULT);
            end
        end

        settle_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== chassis_velocity_ramp_planner.f =====
hdl/crp_pkg.sv
hdl/crp_measure.sv
hdl/crp_ramp_axis.sv
hdl/chassis_velocity_ramp_planner.sv
verif/chassis_velocity_ramp_planner_tb.sv
